// ===== rtl/mskc_pkg.sv =====
// Shared package for the max-spacing k-clustering core.
// Holds defaults, register indexes, field widths and the union-find control structs.
// No dependencies.
package mskc_pkg;

	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_MAX_EDGES    = 1024;
	localparam int DEF_WEIGHT_BITS  = 32;

	localparam int VTX_W = 8;   // vertex index field width
	localparam int WGT_W = 32;  // edge weight / spacing field width
	localparam int CFG_W = 9;   // configuration register width

	localparam logic REG_CLUSTER_COUNT = 1'b0;
	localparam logic REG_VERTEX_COUNT  = 1'b1;

	localparam logic [CFG_W-1:0] CLUSTER_COUNT_RST = 9'd2;
	localparam logic [CFG_W-1:0] VERTEX_COUNT_RST  = 9'd256;

	// commands to the union-find unit, one-cycle pulses
	typedef struct packed {
		logic init;   // reset every parent to itself
		logic query;  // find roots of both endpoints
		logic link;   // parent[root_a] <= root_b
	} uf_cmd_t;

	// status from the union-find unit
	typedef struct packed {
		logic done;   // pulse: init or query finished
		logic same;   // query result: both endpoints share a root
	} uf_sts_t;

endpackage

// ===== rtl/mskc_uf.sv =====
// Union-find unit: parent table memory with init sweep, root finds and link.
// Depends on mskc_pkg.
module mskc_uf #(
	parameter int MAX_VERTICES = mskc_pkg::DEF_MAX_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mskc_pkg::uf_cmd_t   cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0] src_v,
	input  logic [$clog2(MAX_VERTICES)-1:0] dst_v,
	output mskc_pkg::uf_sts_t   sts
);
	import mskc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_INIT = 3'd1;
	localparam logic [2:0] U_FA   = 3'd2;
	localparam logic [2:0] U_FAW  = 3'd3;
	localparam logic [2:0] U_FB   = 3'd4;
	localparam logic [2:0] U_FBW  = 3'd5;

	logic [VW-1:0] par_mem [MAX_VERTICES];
	logic [VW-1:0] par_q;
	logic [2:0]    state_q;
	logic [VW-1:0] ic_q, v_q, a_q, b_q, dst_q;
	logic          done_q, same_q;

	logic          rd_en, wr_en;
	logic [VW-1:0] rd_addr, wr_addr, wr_data;

	always_comb begin
		rd_en   = (state_q == U_FA) || (state_q == U_FB);
		rd_addr = v_q;
		wr_en   = 1'b0;
		wr_addr = ic_q;
		wr_data = ic_q;
		if (state_q == U_INIT) begin
			wr_en = 1'b1;
		end else if (state_q == U_IDLE && cmd.link) begin
			wr_en   = 1'b1;
			wr_addr = a_q;
			wr_data = b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			par_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			par_q <= par_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			ic_q    <= '0;
			v_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			dst_q   <= '0;
			done_q  <= 1'b0;
			same_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (cmd.init) begin
						ic_q    <= '0;
						state_q <= U_INIT;
					end else if (cmd.query) begin
						v_q     <= src_v;
						dst_q   <= dst_v;
						state_q <= U_FA;
					end
				end
				U_INIT: begin
					if (ic_q == VW'(MAX_VERTICES - 1)) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
					ic_q <= ic_q + 1'b1;
				end
				U_FA: state_q <= U_FAW;
				U_FAW: begin
					if (par_q == v_q) begin
						a_q     <= v_q;
						v_q     <= dst_q;
						state_q <= U_FB;
					end else begin
						v_q     <= par_q;
						state_q <= U_FA;
					end
				end
				U_FB: state_q <= U_FBW;
				U_FBW: begin
					if (par_q == v_q) begin
						b_q     <= v_q;
						same_q  <= (a_q == v_q);
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						v_q     <= par_q;
						state_q <= U_FB;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.same = same_q;

endmodule

// ===== rtl/max_spacing_k_clustering_core.sv =====
// Top level of the max-spacing k-clustering core: edge store, min-weight scan, sequencer.
// Depends on mskc_pkg and mskc_uf.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata {weight,dst,src}, s_tlast = last edge
// m_*       out  m_tvalid/m_tready  m_tdata spacing, m_tuser found
// cfg_*     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Edges load one per cycle while idle. After the last edge the sequencer runs:
// parent sweep over all MAX_VERTICES entries, then per Kruskal step one full scan of
// the E stored edges (one edge-memory read a cycle) for the next edge in (weight,
// arrival) order, a check state, and the two finds, which read one parent per hop;
// s_tready is low throughout.
// Reset clears control state only; the edge store is never cleared (reads stay
// below the fill count). A pending result holds until m_tready; loads continue.
module max_spacing_k_clustering_core #(
	parameter int MAX_VERTICES = mskc_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = mskc_pkg::DEF_MAX_EDGES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [47:0]                s_tdata,   // src_vertex[7:0], dst_vertex[15:8], edge_weight[47:16]
	input  logic                       s_tlast,   // last_edge
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // spacing[31:0]
	output logic                       m_tuser,   // found
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [mskc_pkg::CFG_W-1:0] cfg_data
);
	import mskc_pkg::*;

	localparam int WEIGHT_BITS = DEF_WEIGHT_BITS;
	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NVW = $clog2(MAX_VERTICES + 1);
	localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW  = $clog2(MAX_EDGES + 1);
	localparam int EW  = 2 * VTX_W + WEIGHT_BITS;

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_INIT  = 3'd1;
	localparam logic [2:0] T_SCAN  = 3'd2;
	localparam logic [2:0] T_CHECK = 3'd3;
	localparam logic [2:0] T_FIND  = 3'd4;
	localparam logic [2:0] T_DONE  = 3'd5;

	// configuration
	logic [CFG_W-1:0] cc_q, vc_q;
	logic [NVW-1:0]   nv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CLUSTER_COUNT_RST;
			vc_q <= VERTEX_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLUSTER_COUNT: cc_q <= cfg_data;
				REG_VERTEX_COUNT:  vc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// vertex count saturates at the table depth
	assign nv = (32'(vc_q) > 32'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : NVW'(vc_q);

	logic [2:0]       state_q;
	logic [TW-1:0]    total_q, sc_q;
	logic [NVW-1:0]   set_cnt_q;

	// edge store, written on load, read during scans
	logic [EW-1:0]    edge_mem [MAX_EDGES];
	logic [EW-1:0]    rdata_s1;
	logic             rv_s1;
	logic [TW-1:0]    ridx_s1;
	logic             wr_en, rd_en;
	logic [EW-1:0]    wr_word;

	assign s_tready = (state_q == T_IDLE);
	assign wr_en    = s_tvalid && s_tready && (32'(total_q) < 32'(MAX_EDGES));
	assign wr_word  = {WEIGHT_BITS'(s_tdata[47:16]), s_tdata[15:8], s_tdata[7:0]};
	assign rd_en    = (state_q == T_SCAN) && (sc_q != total_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			edge_mem[total_q[AW-1:0]] <= wr_word;
		end
		if (rd_en) begin
			rdata_s1 <= edge_mem[sc_q[AW-1:0]];
		end
	end

	// candidate from the read stage
	logic [VTX_W-1:0]       c_src, c_dst;
	logic [WEIGHT_BITS-1:0] c_w;
	assign c_src = rdata_s1[VTX_W-1:0];
	assign c_dst = rdata_s1[2*VTX_W-1:VTX_W];
	assign c_w   = rdata_s1[EW-1:2*VTX_W];

	// previous pick and running best
	logic                   have_prev_q, bval_q;
	logic [WEIGHT_BITS-1:0] pw_q, bw_q;
	logic [TW-1:0]          pidx_q, bidx_q;
	logic [VTX_W-1:0]       bsrc_q, bdst_q;
	logic                   qualify, better;

	// strictly after the previous pick in (weight, arrival) order
	assign qualify = !have_prev_q || (c_w > pw_q) || ((c_w == pw_q) && (ridx_s1 > pidx_q));
	// scan runs in arrival order, so strict less keeps the earliest of equals
	assign better  = !bval_q || (c_w < bw_q);

	// union-find unit
	uf_cmd_t uf_cmd;
	uf_sts_t uf_sts;

	mskc_uf #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_uf (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (uf_cmd),
		.src_v  (VW'(bsrc_q)),
		.dst_v  (VW'(bdst_q)),
		.sts    (uf_sts)
	);

	logic endpoints_ok;
	assign endpoints_ok = (32'(bsrc_q) < 32'(nv)) && (32'(bdst_q) < 32'(nv));

	always_comb begin
		uf_cmd       = '0;
		uf_cmd.init  = s_tvalid && s_tready && s_tlast;
		uf_cmd.query = (state_q == T_CHECK) && endpoints_ok;
		uf_cmd.link  = (state_q == T_FIND) && uf_sts.done && !uf_sts.same &&
		               (32'(set_cnt_q) != 32'(cc_q));
	end

	// result and output register
	logic        res_found_q;
	logic [31:0] res_spc_q;
	logic        m_tvalid_q, m_tuser_q;
	logic [31:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			total_q     <= '0;
			sc_q        <= '0;
			rv_s1       <= 1'b0;
			ridx_s1     <= '0;
			set_cnt_q   <= '0;
			have_prev_q <= 1'b0;
			bval_q      <= 1'b0;
			pw_q        <= '0;
			bw_q        <= '0;
			pidx_q      <= '0;
			bidx_q      <= '0;
			bsrc_q      <= '0;
			bdst_q      <= '0;
			res_found_q <= 1'b0;
			res_spc_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tuser_q   <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			rv_s1   <= rd_en;
			ridx_s1 <= sc_q;
			case (state_q)
				T_IDLE: begin
					if (wr_en) begin
						total_q <= total_q + 1'b1;
					end
					if (s_tvalid && s_tready && s_tlast) begin
						state_q <= T_INIT;
					end
				end
				T_INIT: begin
					set_cnt_q   <= nv;
					have_prev_q <= 1'b0;
					sc_q        <= '0;
					bval_q      <= 1'b0;
					if (uf_sts.done) begin
						if (32'(cc_q) > 32'(nv)) begin
							res_found_q <= 1'b0;
							state_q     <= T_DONE;
						end else begin
							state_q <= T_SCAN;
						end
					end
				end
				T_SCAN: begin
					if (rd_en) begin
						sc_q <= sc_q + 1'b1;
					end
					if (rv_s1 && qualify && better) begin
						bval_q <= 1'b1;
						bw_q   <= c_w;
						bidx_q <= ridx_s1;
						bsrc_q <= c_src;
						bdst_q <= c_dst;
					end
					if (!rd_en && !rv_s1) begin
						if (bval_q) begin
							have_prev_q <= 1'b1;
							pw_q        <= bw_q;
							pidx_q      <= bidx_q;
							state_q     <= T_CHECK;
						end else begin
							res_found_q <= 1'b0;
							state_q     <= T_DONE;
						end
					end
				end
				T_CHECK: begin
					sc_q   <= '0;
					bval_q <= 1'b0;
					state_q <= endpoints_ok ? T_FIND : T_SCAN;
				end
				T_FIND: begin
					if (uf_sts.done) begin
						if (uf_sts.same) begin
							state_q <= T_SCAN;
						end else if (32'(set_cnt_q) == 32'(cc_q)) begin
							res_found_q <= 1'b1;
							res_spc_q   <= 32'(bw_q);
							state_q     <= T_DONE;
						end else begin
							set_cnt_q <= set_cnt_q - 1'b1;
							state_q   <= T_SCAN;
						end
					end
				end
				T_DONE: begin
					// wait for the output register to free up
					if (!m_tvalid_q) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_found_q;
						m_tdata_q  <= res_found_q ? res_spc_q : 32'd0;
						total_q    <= '0;
						state_q    <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a failure transaction always carries zero spacing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
		else $error("failure result with nonzero spacing");

	// fill count never passes the store depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= 32'(MAX_EDGES))
		else $error("edge count overflow");

	// merges stop at k sets, so the set count never drops below k while searching
	a_sets_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_FIND) |-> (32'(set_cnt_q) >= 32'(cc_q)))
		else $error("set count below cluster count");

	// scan read addresses stay below the fill count
	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (sc_q < total_q))
		else $error("scan read past stored edges");

endmodule
